// ===== hdl/sctp_pkg.sv =====
`default_nettype none

package sctp_pkg;

  localparam int SLOT_W      = 4;
  localparam int DEV_W       = 8;
  localparam int BLK_W       = 32;
  localparam int FUNC_W      = 2;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_READ   = 2'd0,
    FN_WRITE  = 2'd1,
    FN_FLUSH  = 2'd2,
    FN_IGNORE = 2'd3
  } func_t;

  // Request travelling along the row of cells.
  typedef struct packed {
    logic              live;
    func_t             fn;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic              done;
    logic              seen_free;
    logic              vwb;
    logic [DEV_W-1:0]  vdev;
    logic [BLK_W-1:0]  vblk;
    logic [CNT_W-1:0]  count;
    logic              phave;
    logic [SLOT_W-1:0] pslot;
    logic [DEV_W-1:0]  pdev;
    logic [BLK_W-1:0]  pblk;
  } tok_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              wb;
    logic [DEV_W-1:0]  wdev;
    logic [BLK_W-1:0]  wblk;
    logic              fill;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             en;
    logic             hit;
    logic             write;
    logic             apply_age;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
  } cmt_t;

endpackage

`default_nettype wire

// ===== hdl/sctp_cell.sv =====
`default_nettype none

module sctp_cell import sctp_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int AGE_BITS = 16,
  parameter int INDEX    = 0,
  localparam int IDX_W   = $clog2(ENTRIES)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire tok_t                tok_in,
  input  wire logic [AGE_BITS-1:0] oldest_in,
  input  wire logic [IDX_W-1:0]    vic_in,
  input  wire cmt_t                cmt,
  input  wire logic [IDX_W-1:0]    cmt_target,
  output tok_t                     tok_out,
  output logic [AGE_BITS-1:0]      oldest_out,
  output logic [IDX_W-1:0]         vic_out,
  output logic                     em_valid,
  output res_t                     em
);

  localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(INDEX);
  localparam logic [SLOT_W-1:0]   MY_SLOT = SLOT_W'(INDEX);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

  logic                valid;
  logic                dirty;
  logic                pend;
  logic [DEV_W-1:0]    dev_tag;
  logic [BLK_W-1:0]    blk_tag;
  logic [AGE_BITS-1:0] age;

  logic                live_q;
  tok_t                tok_q;
  logic [AGE_BITS-1:0] oldest_q;
  logic [IDX_W-1:0]    vic_q;

  tok_t                tok_n;
  logic [AGE_BITS-1:0] oldest_n;
  logic [IDX_W-1:0]    vic_n;
  logic                match;
  logic                set_pend;
  logic                clean;
  logic                target_me;

  assign match     = valid && (dev_tag == tok_in.dev) && (blk_tag == tok_in.blk);
  assign target_me = (cmt_target == MY_IDX);

  always_comb begin
    tok_n    = tok_in;
    oldest_n = oldest_in;
    vic_n    = vic_in;
    em_valid = 1'b0;
    em       = '0;
    set_pend = 1'b0;
    clean    = 1'b0;
    if (tok_in.live) begin
      unique case (tok_in.fn) inside
        FN_READ, FN_WRITE: begin
          if (!tok_in.done) begin
            if (match) begin
              tok_n.done = 1'b1;
              vic_n      = MY_IDX;
            end else if (valid) begin
              if (!tok_in.seen_free) begin
                set_pend = 1'b1;
                if (oldest_in < age) begin
                  oldest_n   = age;
                  vic_n      = MY_IDX;
                  tok_n.vwb  = dirty;
                  tok_n.vdev = dev_tag;
                  tok_n.vblk = blk_tag;
                end
              end
            end else begin
              vic_n           = MY_IDX;
              tok_n.seen_free = 1'b1;
              tok_n.vwb       = 1'b0;
            end
          end
        end
        FN_FLUSH: begin
          if (valid && dirty && (tok_in.count < CNT_W'(MAX_RESULTS))) begin
            clean       = 1'b1;
            tok_n.count = tok_in.count + 1'b1;
            tok_n.phave = 1'b1;
            tok_n.pslot = MY_SLOT;
            tok_n.pdev  = dev_tag;
            tok_n.pblk  = blk_tag;
            // The word held from an earlier entry is known not to be the last.
            if (tok_in.phave) begin
              em_valid = 1'b1;
              em.wb    = 1'b1;
              em.slot  = tok_in.pslot;
              em.wdev  = tok_in.pdev;
              em.wblk  = tok_in.pblk;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      dirty  <= 1'b0;
      pend   <= 1'b0;
      live_q <= 1'b0;
    end else if (adv) begin
      live_q <= tok_in.live;
      if (set_pend) begin
        pend <= 1'b1;
      end
      if (clean) begin
        dirty <= 1'b0;
      end
      if (cmt.en) begin
        pend <= 1'b0;
        if (target_me) begin
          if (cmt.hit) begin
            if (cmt.write) begin
              dirty <= 1'b1;
            end
          end else begin
            valid <= 1'b1;
            dirty <= cmt.write;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_q    <= tok_n;
      oldest_q <= oldest_n;
      vic_q    <= vic_n;
      if (cmt.en) begin
        if (target_me) begin
          age <= AGE_ONE;
          if (!cmt.hit) begin
            dev_tag <= cmt.dev;
            blk_tag <= cmt.blk;
          end
        end else if (pend && cmt.apply_age && (age != AGE_MAX)) begin
          age <= age + 1'b1;
        end
      end
    end
  end

  always_comb begin
    tok_out      = tok_q;
    tok_out.live = live_q;
  end

  assign oldest_out = oldest_q;
  assign vic_out    = vic_q;

endmodule

`default_nettype wire

// ===== hdl/sector_cache_tag_policy.sv =====
`default_nettype none

// Channel   Handshake               Payload
// in        in_valid / in_ready     func, device_id, block_number
// out       out_valid / out_ready   hit, slot, need_writeback, wb_device, wb_block,
//                                   need_fill, last
//
// A request enters a head register and then moves through one cell per cycle unless the
// row is stopped, passing the register of every cell before its result word is loaded.
// The next request is accepted only after the previous one has left the end of the row,
// so a new request cannot enter while one is still travelling along the row.
// The row stops only when a word must be loaded while the output still holds one.
// Reset clears valid and dirty bits at once; tags and ages are not reset.

module sector_cache_tag_policy import sctp_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int AGE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [FUNC_W-1:0] func,
  input  wire logic [DEV_W-1:0]  device_id,
  input  wire logic [BLK_W-1:0]  block_number,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   hit,
  output logic [SLOT_W-1:0]      slot,
  output logic                   need_writeback,
  output logic [DEV_W-1:0]       wb_device,
  output logic [BLK_W-1:0]       wb_block,
  output logic                   need_fill,
  output logic                   last
);

  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int DEF_VICTIM = 1 % ENTRIES;

  logic                busy;
  logic                head_live;
  tok_t                head_tok;
  tok_t                head_next;
  tok_t                head_in;
  logic                adv;
  logic                accept;

  tok_t                tok_c [ENTRIES+1];
  logic [AGE_BITS-1:0] old_c [ENTRIES+1];
  logic [IDX_W-1:0]    vic_c [ENTRIES+1];
  res_t                em_c  [ENTRIES];
  logic [ENTRIES-1:0]  em_v;
  logic [ENTRIES:0]    live_vec;

  tok_t                fin;
  logic [IDX_W-1:0]    fin_vic;
  res_t                fin_em;
  logic                fin_em_v;
  cmt_t                cmt;
  res_t                em_sel;
  logic                em_any;
  res_t                out_res;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy;

  always_comb begin
    head_in      = head_tok;
    head_in.live = head_live;
  end

  always_comb begin
    head_next     = '0;
    head_next.fn  = func_t'(func);
    head_next.dev = device_id;
    head_next.blk = block_number;
  end

  assign tok_c[0] = head_in;
  assign old_c[0] = '0;
  assign vic_c[0] = IDX_W'(DEF_VICTIM);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sctp_cell #(
      .ENTRIES  (ENTRIES),
      .AGE_BITS (AGE_BITS),
      .INDEX    (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .tok_in     (tok_c[g]),
      .oldest_in  (old_c[g]),
      .vic_in     (vic_c[g]),
      .cmt        (cmt),
      .cmt_target (fin_vic),
      .tok_out    (tok_c[g+1]),
      .oldest_out (old_c[g+1]),
      .vic_out    (vic_c[g+1]),
      .em_valid   (em_v[g]),
      .em         (em_c[g])
    );
  end

  assign fin     = tok_c[ENTRIES];
  assign fin_vic = vic_c[ENTRIES];

  always_comb begin
    fin_em_v = 1'b0;
    fin_em   = '0;
    cmt      = '0;
    if (fin.live) begin
      unique case (fin.fn) inside
        FN_READ, FN_WRITE: begin
          fin_em_v    = 1'b1;
          fin_em.hit  = fin.done;
          fin_em.slot = SLOT_W'(fin_vic);
          fin_em.wb   = !fin.done && fin.vwb;
          if (!fin.done && fin.vwb) begin
            fin_em.wdev = fin.vdev;
            fin_em.wblk = fin.vblk;
          end
          fin_em.fill   = !fin.done && (fin.fn == FN_READ);
          fin_em.last   = 1'b1;
          cmt.en        = 1'b1;
          cmt.hit       = fin.done;
          cmt.write     = (fin.fn == FN_WRITE);
          cmt.apply_age = !((fin.fn == FN_WRITE) && fin.done);
          cmt.dev       = fin.dev;
          cmt.blk       = fin.blk;
        end
        FN_FLUSH: begin
          if (fin.phave) begin
            fin_em_v    = 1'b1;
            fin_em.slot = fin.pslot;
            fin_em.wb   = 1'b1;
            fin_em.wdev = fin.pdev;
            fin_em.wblk = fin.pblk;
            fin_em.last = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    em_sel = fin_em;
    em_any = fin_em_v;
    for (int k = 0; k < ENTRIES; k++) begin
      em_sel = res_t'(em_sel | em_c[k]);
      em_any = em_any | em_v[k];
    end
  end

  always_comb begin
    for (int k = 0; k <= ENTRIES; k++) begin
      live_vec[k] = tok_c[k].live;
    end
  end

  assign adv = !(em_any && out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      head_live <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (adv && fin.live) begin
        busy <= 1'b0;
      end
      if (accept) begin
        head_live <= 1'b1;
      end else if (adv) begin
        head_live <= 1'b0;
      end
      if (em_any && adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_tok <= head_next;
    end
    if (em_any && adv) begin
      out_res <= em_sel;
    end
  end

  assign hit            = out_res.hit;
  assign slot           = out_res.slot;
  assign need_writeback = out_res.wb;
  assign wb_device      = out_res.wdev;
  assign wb_block       = out_res.wblk;
  assign need_fill      = out_res.fill;
  assign last           = out_res.last;

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    $onehot0(live_vec))
    else $error("More than one request is travelling along the row.");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (live_vec == '0))
    else $error("Input is ready while a request is still in the row.");

  a_hit_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (last && !need_writeback && !need_fill))
    else $error("A hit word carries a writeback or fill request.");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    em_any |-> busy)
    else $error("A word is emitted with no request in progress.");

endmodule

`default_nettype wire
